// ----- sv/gapf_pkg.sv -----
// shared widths, routing codes and controller/datapath interface types for the gap fill core
package gapf_pkg;

    localparam int DATA_W      = 32;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int GAP_W       = 6;
    localparam int DIVISOR_W   = GAP_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIFF_W + 1);
    localparam int MAX_GAP_DEF = 63;

    // what an accepted sample leads to
    typedef enum logic [1:0] {
        ROUTE_HOLD = 2'd0,
        ROUTE_EMIT = 2'd1,
        ROUTE_DIV  = 2'd2
    } route_t;

    typedef struct packed {
        logic accept;
        logic div_run;
        logic emit;
    } gapf_cmd_t;

    typedef struct packed {
        route_t route;
        logic   div_done;
        logic   fill_zero;
        logic   out_free;
    } gapf_status_t;

endpackage

// ----- sv/gapf_div.sv -----
// restoring divider, one quotient bit per cycle while run is high, for the interpolation step
module gapf_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 run,
    input  logic [gapf_pkg::DIFF_W-1:0]          dividend,
    input  logic [gapf_pkg::DIVISOR_W-1:0]       divisor,
    output logic [gapf_pkg::DIFF_W-1:0]          quotient,
    output logic                                 done
);

    logic [gapf_pkg::DIFF_W-1:0]    quo_reg, quo_next;
    logic [gapf_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [gapf_pkg::DIVISOR_W-1:0] den_reg;
    logic [gapf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [gapf_pkg::DIVISOR_W:0]   trial;
    logic                           fits;

    assign done  = (cnt_reg == gapf_pkg::DIV_CNT_W'(gapf_pkg::DIFF_W));
    assign trial = {rem_reg, quo_reg[gapf_pkg::DIFF_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (run && !done)
        begin
            quo_next = {quo_reg[gapf_pkg::DIFF_W-2:0], fits};
            rem_next = fits ? gapf_pkg::DIVISOR_W'(trial - {1'b0, den_reg})
                            : trial[gapf_pkg::DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// ----- sv/gapf_dpath.sv -----
// datapath: curve state, gap bookkeeping, step accumulation and output register
module gapf_dpath #(
    parameter int MAX_GAP = gapf_pkg::MAX_GAP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [gapf_pkg::DATA_W-1:0]       sample,
    input  logic                              end_of_curve,
    input  logic                              out_stall,
    input  gapf_pkg::gapf_cmd_t               cmd,
    output gapf_pkg::gapf_status_t            status,
    output logic                              out_valid,
    output logic [gapf_pkg::DATA_W-1:0]       value,
    output logic                              run_last,
    output logic                              curve_last,
    output logic                              overlong
);

    // curve state
    logic [gapf_pkg::DATA_W-1:0] anchor_reg;
    logic [gapf_pkg::GAP_W-1:0]  gap_reg;
    logic                        ovf_reg;
    logic                        start_reg;

    // current run
    logic [gapf_pkg::DATA_W-1:0] sample_reg;
    logic                        last_reg;
    logic                        ov_reg;
    logic [gapf_pkg::GAP_W-1:0]  fill_reg;
    logic [gapf_pkg::DATA_W-1:0] acc_reg;
    logic                        neg_reg;

    // output register
    logic                        out_valid_reg;
    logic [gapf_pkg::DATA_W-1:0] out_value_reg;
    logic                        out_run_last_reg;
    logic                        out_curve_last_reg;
    logic                        out_overlong_reg;

    logic                              s_zero;
    gapf_pkg::route_t                  route;
    logic [gapf_pkg::DIFF_W-1:0]       diff;
    logic [gapf_pkg::DIFF_W-1:0]       mag;
    logic [gapf_pkg::DIFF_W-1:0]       div_in;
    logic [gapf_pkg::DIVISOR_W-1:0]    divisor;
    logic [gapf_pkg::DIFF_W-1:0]       quotient;
    logic                              div_done;
    logic [gapf_pkg::DATA_W-1:0]       step;
    logic [gapf_pkg::DATA_W-1:0]       fill_value;
    logic                              out_free;

    assign s_zero  = (sample == '0);
    assign diff    = {sample[gapf_pkg::DATA_W-1], sample}
                   - {anchor_reg[gapf_pkg::DATA_W-1], anchor_reg};
    assign mag     = diff[gapf_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign div_in  = s_zero ? '0 : mag;
    assign divisor = {1'b0, gap_reg} + 1'b1;

    always_comb
    begin
        if (start_reg)
            route = gapf_pkg::ROUTE_EMIT;
        else if (s_zero && !end_of_curve)
            route = gapf_pkg::ROUTE_HOLD;
        else if (s_zero || gap_reg == '0)
            route = gapf_pkg::ROUTE_EMIT;
        else
            route = gapf_pkg::ROUTE_DIV;
    end

    gapf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept),
        .run      (cmd.div_run),
        .dividend (div_in),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // truncation toward zero: quotient of the magnitude, sign of the difference
    assign step       = neg_reg ? (~quotient[gapf_pkg::DATA_W-1:0] + 1'b1)
                                : quotient[gapf_pkg::DATA_W-1:0];
    assign fill_value = acc_reg + step;
    assign out_free   = !out_valid_reg || !out_stall;

    assign status.route     = route;
    assign status.div_done  = div_done;
    assign status.fill_zero = (fill_reg == '0);
    assign status.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg <= '0;
            gap_reg    <= '0;
            ovf_reg    <= 1'b0;
            start_reg  <= 1'b1;
        end
        else if (cmd.accept)
        begin
            if (route == gapf_pkg::ROUTE_HOLD)
            begin
                if (gap_reg < gapf_pkg::GAP_W'(MAX_GAP))
                    gap_reg <= gap_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            else
            begin
                anchor_reg <= end_of_curve ? '0 : sample;
                gap_reg    <= '0;
                ovf_reg    <= 1'b0;
                start_reg  <= end_of_curve;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
            last_reg   <= end_of_curve;
            ov_reg     <= start_reg ? 1'b0 : ovf_reg;
            fill_reg   <= start_reg ? '0 : gap_reg;
            acc_reg    <= (start_reg || s_zero) ? '0 : anchor_reg;
            neg_reg    <= diff[gapf_pkg::DIFF_W-1];
        end
        else if (cmd.emit && fill_reg != '0)
        begin
            acc_reg  <= fill_value;
            fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_overlong_reg <= ov_reg;
            if (fill_reg != '0)
            begin
                out_value_reg      <= fill_value;
                out_run_last_reg   <= 1'b0;
                out_curve_last_reg <= 1'b0;
            end
            else
            begin
                out_value_reg      <= sample_reg;
                out_run_last_reg   <= 1'b1;
                out_curve_last_reg <= last_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = out_value_reg;
    assign run_last   = out_run_last_reg;
    assign curve_last = out_curve_last_reg;
    assign overlong   = out_overlong_reg;

endmodule

// ----- sv/gapf_ctrl.sv -----
// controller state machine: accept, divide, emit sequencing
module gapf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  gapf_pkg::gapf_status_t status,
    output gapf_pkg::gapf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.route)
                        gapf_pkg::ROUTE_EMIT: state_next = ST_EMIT;
                        gapf_pkg::ROUTE_DIV:  state_next = ST_DIV;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.fill_zero)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.accept  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.div_run = (state_reg == ST_DIV);
    assign cmd.emit    = (state_reg == ST_EMIT) && status.out_free;

endmodule

// ----- sv/curve_gap_linear_fill_core.sv -----
// top level of the curve gap linear fill core
//
//  channel   handshake                   payload
//  input     in_valid / in_stall         sample, end_of_curve
//  output    out_valid / out_stall       value, run_last, curve_last, overlong
//
// a zero sample inside a curve is accepted and gives no transaction
// a first sample, or a nonzero sample with no gap, is accepted, then emitted
// closing a gap of g zeros: the sample is accepted, then the 33-bit restoring
// divider makes one quotient bit per cycle, then one result per cycle follows while out_stall allows
// rst_n clears the controller, the curve state and the output valid asynchronously
// out_stall holds the output register and pauses the emit sequence while a result
// waits there; a new input transaction is taken while the last result of the
// previous one still waits
module curve_gap_linear_fill_core #(
    parameter int MAX_GAP = gapf_pkg::MAX_GAP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gapf_pkg::DATA_W-1:0]   sample,
    input  logic                          end_of_curve,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gapf_pkg::DATA_W-1:0]   value,
    output logic                          run_last,
    output logic                          curve_last,
    output logic                          overlong
);

    // command and status between the controller and the datapath
    gapf_pkg::gapf_cmd_t    cmd;
    gapf_pkg::gapf_status_t status;

    // controller: idle / divide / emit sequencing
    gapf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: anchor and gap tracking, step divider, fill accumulator, output register
    gapf_dpath #(
        .MAX_GAP (MAX_GAP)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .end_of_curve (end_of_curve),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .value        (value),
        .run_last     (run_last),
        .curve_last   (curve_last),
        .overlong     (overlong)
    );

endmodule
